>>> rtl/core/cfrx_pkg.sv
// ----------------------------------------------------------------------------
// cfrx_pkg
// Shared types and constants for the checksummed command frame receiver.
// ----------------------------------------------------------------------------
package cfrx_pkg;

	// Bytes in one complete frame, and bytes covered by the checksum.
	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned SUM_LEN   = 9;

	// The byte count holds 0 to SUM_LEN.
	localparam int unsigned CNT_W = $clog2(FRAME_LEN);

	// Register indexes on the configuration port.
	localparam logic REG_HOST_ID  = 1'b0;
	localparam logic REG_SLAVE_ID = 1'b1;

	// One decoded command.
	typedef struct packed {
		logic [7:0]  wr_code;
		logic [7:0]  device;
		logic [7:0]  reg_address;
		logic [31:0] value;
	} cmd_t;

endpackage

>>> rtl/core/checksummed_command_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// checksummed_command_frame_receiver_top
// Assembles ten-byte command frames from received bytes and issues one
// command for each frame whose slave id and checksum are correct.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload                    Direction
//  -------  ------------------------  -------------------------  ---------
//  input    in_valid / in_ready       rx_byte                    in
//  output   out_valid / out_ready     wr_code, device,           out
//                                     reg_address, value
//  config   psel/penable/pwrite/...   paddr, pwdata, prdata      in/out
//
// Each byte is captured in the input register and checked against the frame
// state by the assembler, and a command from a good frame is then written to
// the output register. A new byte can be taken in every cycle while the
// pipeline moves. When the output register holds a command that has not
// been taken, the pipeline stops and in_ready falls only while the input
// register is also full. The asynchronous reset clears the frame count,
// the running sum, both id registers and the valid flags.
//
// Rejected frames and bytes seen while idle that do not match host_id are
// dropped without any transfer on the output.
// ----------------------------------------------------------------------------
module checksummed_command_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	// Received bytes.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// Commands.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  wr_code,
	output logic [7:0]  device,
	output logic [7:0]  reg_address,
	output logic [31:0] value,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic           step;
	logic           hit;
	cfrx_pkg::cmd_t cmd;
	cfrx_pkg::cmd_t cmd_q;
	logic           out_valid_q;
	logic [7:0]     host_id_q;
	logic [7:0]     slave_id_q;

	// Configuration registers. Bit two of paddr selects the register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_id_q  <= '0;
			slave_id_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				cfrx_pkg::REG_HOST_ID:  host_id_q  <= pwdata[7:0];
				cfrx_pkg::REG_SLAVE_ID: slave_id_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cfrx_pkg::REG_HOST_ID:  prdata = {24'd0, host_id_q};
			cfrx_pkg::REG_SLAVE_ID: prdata = {24'd0, slave_id_q};
			default:                prdata = '0;
		endcase
	end

	// The pipeline moves whenever the output register is empty or being
	// emptied in this cycle.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	cfrx_assembler u_assembler (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.host_id  (host_id_q),
		.slave_id (slave_id_q),
		.hit      (hit),
		.cmd      (cmd)
	);

	// Output register: holds a finished command until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			cmd_q <= cmd;
		end
	end

	assign out_valid   = out_valid_q;
	assign wr_code     = cmd_q.wr_code;
	assign device      = cmd_q.device;
	assign reg_address = cmd_q.reg_address;
	assign value       = cmd_q.value;

endmodule

>>> rtl/core/cfrx_assembler.sv
// ----------------------------------------------------------------------------
// cfrx_assembler
// Frame state: byte count, running sum and the stored frame bytes, with the
// combinational check of the closing byte.
// ----------------------------------------------------------------------------
module cfrx_assembler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         byte_in,
	input  logic [7:0]         host_id,
	input  logic [7:0]         slave_id,
	output logic               hit,
	output cfrx_pkg::cmd_t     cmd
);

	logic [cfrx_pkg::CNT_W-1:0] count_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 store_q [1:cfrx_pkg::SUM_LEN-1];

	localparam logic [cfrx_pkg::CNT_W-1:0] CNT_LAST = cfrx_pkg::CNT_W'(cfrx_pkg::SUM_LEN);

	// The closing byte arrives when nine bytes are held.
	assign hit = (count_q == CNT_LAST) && (store_q[1] == slave_id) && (byte_in == sum_q);

	assign cmd.wr_code     = store_q[2];
	assign cmd.device      = store_q[3];
	assign cmd.reg_address = store_q[4];
	assign cmd.value       = {store_q[5], store_q[6], store_q[7], store_q[8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (step) begin
			if (count_q == '0) begin
				if (byte_in == host_id) begin
					count_q <= cfrx_pkg::CNT_W'(1);
					sum_q   <= byte_in;
				end
			end else if (count_q < CNT_LAST) begin
				count_q <= count_q + cfrx_pkg::CNT_W'(1);
				sum_q   <= sum_q + byte_in;
			end else begin
				count_q <= '0;
				sum_q   <= '0;
			end
		end
	end

	// The opening byte equals host_id, so only bytes one to eight are kept.
	always_ff @(posedge clk) begin
		for (int i = 1; i < cfrx_pkg::SUM_LEN; i++) begin
			if (step && (count_q == cfrx_pkg::CNT_W'(i))) begin
				store_q[i] <= byte_in;
			end
		end
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the checksummed command frame receiver.
// ----------------------------------------------------------------------------
// Received bytes wait in a queue. A clocked driver presents them on the
// valid/ready input channel. A clocked monitor runs each accepted byte
// through a frame assembler of its own, which mirrors the block's frame
// count, stored bytes and running sum. Each command that assembler predicts
// is queued, and every command transfer on the output is compared field by
// field with the oldest queued one.
//
// The run opens with a short directed section. It then runs eight random
// phases. Each phase has its own host and slave ids, written over the
// configuration port and read back, and one of four idling patterns on the
// two channels.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 155;
	localparam int SETTLE_CYCLES = 12;

	// Kinds of frame that the stimulus builds.
	typedef enum int {FRM_GOOD, FRM_BAD_SUM, FRM_BAD_SLAVE} frame_kind_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte     = 8'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  wr_code;
	logic [7:0]  device;
	logic [7:0]  reg_address;
	logic [31:0] value;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [2:0]  paddr       = 3'd0;
	logic [31:0] pwdata      = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Bytes still to be sent, and the commands that are owed in return.
	logic [7:0]     byte_q[$];
	cfrx_pkg::cmd_t cmd_q[$];

	// Idling percentages for the current phase.
	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;

	int errors = 0;
	int cycles = 0;

	// The bench's own copy of the id registers and of the frame state.
	logic [7:0]                 host_cfg  = 8'd0;
	logic [7:0]                 slave_cfg = 8'd0;
	logic [cfrx_pkg::CNT_W-1:0] held_cnt  = '0;
	logic [7:0]                 held_bytes [cfrx_pkg::SUM_LEN];
	logic [7:0]                 held_sum  = 8'd0;

	checksummed_command_frame_receiver_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.wr_code     (wr_code),
		.device      (device),
		.reg_address (reg_address),
		.value       (value),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #2 clk = ~clk;

	// Watchdog. It is far beyond the slowest legal run, of roughly 1300 bytes.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Takes one accepted byte into the frame assembler. It returns 1 when
	// the byte completes a frame that passes both the slave and the
	// checksum tests, and then cmd holds the decoded command.
	function automatic bit frame_absorb(input logic [7:0] b, output cfrx_pkg::cmd_t cmd);
		bit ok;
		cmd = '0;
		ok  = 1'b0;
		if (held_cnt == '0) begin
			// While idle, only the host id opens a frame.
			if (b == host_cfg) begin
				held_bytes[0] = b;
				held_sum      = b;
				held_cnt      = cfrx_pkg::CNT_W'(1);
			end
		end else if (held_cnt < cfrx_pkg::SUM_LEN) begin
			held_bytes[held_cnt] = b;
			held_sum             = held_sum + b;
			held_cnt             = held_cnt + cfrx_pkg::CNT_W'(1);
		end else begin
			// This is the checksum byte. A count past it can only close the frame.
			ok = (held_cnt == cfrx_pkg::SUM_LEN) && (held_bytes[1] == slave_cfg) &&
				(b == held_sum);
			held_cnt = '0;
			held_sum = 8'd0;
			if (ok) begin
				cmd.wr_code     = held_bytes[2];
				cmd.device      = held_bytes[3];
				cmd.reg_address = held_bytes[4];
				cmd.value       = {held_bytes[5], held_bytes[6], held_bytes[7], held_bytes[8]};
			end
		end
		return ok;
	endfunction

	task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// The driver moves to the next byte only when the current one has been
	// transferred or nothing is being offered. This keeps valid and the
	// payload steady while the block holds off.
	always @(posedge clk) begin
		if (arst_n && !(in_valid && !in_ready)) begin
			if (byte_q.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte  <= byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The command sink stalls at random at the rate that the phase sets.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= rcv_stall_pct);
	end

	// The monitor predicts from each byte transfer and checks each command
	// transfer. Both are sampled at the same edge at which the block
	// samples them.
	always @(posedge clk) begin : monitor
		cfrx_pkg::cmd_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (frame_absorb(rx_byte, want))
					cmd_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (cmd_q.size() == 0) begin
					$display("%0t: unexpected command, expected none, actual %h %h %h %h",
						$time, wr_code, device, reg_address, value);
					errors++;
				end else begin
					want = cmd_q.pop_front();
					field_check("wr_code", 32'(want.wr_code), 32'(wr_code));
					field_check("device", 32'(want.device), 32'(device));
					field_check("reg_address", 32'(want.reg_address), 32'(reg_address));
					field_check("value", want.value, value);
				end
			end
		end
	end

	// Writes an id register, reads it straight back, and updates the bench's
	// copy. The write lands at the edge that closes the access cycle.
	task automatic cfg_write(input logic idx, input logic [7:0] val);
		logic [31:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[7:0] !== val) begin
			$display("%0t: readback of register %0d, expected %h, actual %h",
				$time, idx, val, rd[7:0]);
			errors++;
		end
		if (idx == cfrx_pkg::REG_HOST_ID)
			host_cfg = val;
		else
			slave_cfg = val;
	endtask

	task automatic set_ids(input logic [7:0] host, input logic [7:0] slave);
		cfg_write(cfrx_pkg::REG_HOST_ID, host);
		cfg_write(cfrx_pkg::REG_SLAVE_ID, slave);
	endtask

	// Queues one ten-byte frame for the current ids. The body holds bytes
	// two to eight, with byte two in the top bits. A bad frame has a non-zero
	// value XORed into either its slave byte or its checksum.
	task automatic push_frame(input logic [55:0] body, input frame_kind_t kind);
		logic [7:0] f [cfrx_pkg::FRAME_LEN];
		logic [7:0] sum;
		f[0] = host_cfg;
		f[1] = (kind == FRM_BAD_SLAVE) ? slave_cfg ^ 8'($urandom_range(255, 1)) : slave_cfg;
		for (int i = 0; i < 7; i++)
			f[2 + i] = body[55 - 8 * i -: 8];
		sum = 8'd0;
		for (int i = 0; i < cfrx_pkg::SUM_LEN; i++)
			sum += f[i];
		f[cfrx_pkg::SUM_LEN] = (kind == FRM_BAD_SUM) ? sum ^ 8'($urandom_range(255, 1)) : sum;
		foreach (f[i])
			byte_q.push_back(f[i]);
	endtask

	// Payload bytes lean towards the extremes.
	function automatic logic [7:0] rand_byte();
		int unsigned roll;
		roll = $urandom_range(7, 0);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Most of the traffic is well-formed frames with random content. The
	// rest is frames that fail a check, plus short bursts of line noise.
	// A noise byte can now and then open a frame and push later frames
	// out of step.
	task automatic push_random();
		int unsigned roll;
		logic [55:0] body;
		roll = $urandom_range(99, 0);
		for (int i = 0; i < 7; i++)
			body[8 * i +: 8] = rand_byte();
		if (roll < 65)
			push_frame(body, FRM_GOOD);
		else if (roll < 75)
			push_frame(body, FRM_BAD_SUM);
		else if (roll < 85)
			push_frame(body, FRM_BAD_SLAVE);
		else
			repeat ($urandom_range(4, 1)) byte_q.push_back(8'($urandom));
	endtask

	// Waits until every byte has been sent and every command returned. It
	// then allows for a rejected frame that may still be in the pipeline.
	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || cmd_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed section, with no idling on either channel. It sends a
		// stray byte while idle, then a good frame whose payload swings
		// between all-zero and all-one bytes, so the checksum wraps. A
		// frame with a bad checksum and one with the wrong slave id follow.
		set_ids(8'hA5, 8'h3C);
		byte_q.push_back(8'h00);
		push_frame({8'hFF, 8'h00, 8'hFF, 32'h00FF_00FF}, FRM_GOOD);
		push_frame({8'h00, 8'hFF, 8'h00, 32'hFF00_FF00}, FRM_BAD_SUM);
		push_frame({8'h12, 8'h34, 8'h56, 32'h789A_BCDE}, FRM_BAD_SLAVE);
		wait_idle();

		// Random phases. Each phase has its own pair of ids, the extremes
		// among them, and one of four idling patterns.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_ids(8'h00, 8'h00);
				1: set_ids(8'hFF, 8'hFF);
				2: set_ids(8'h00, 8'hFF);
				3: set_ids(8'hFF, 8'h00);
				default: set_ids(8'($urandom), 8'($urandom));
			endcase
			case (p % 4)
				0: begin
					snd_idle_pct  = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					snd_idle_pct  = 81;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct  = 0;
					rcv_stall_pct = 81;
				end
				default: begin
					snd_idle_pct  = 19;
					rcv_stall_pct = 19;
				end
			endcase
			while (byte_q.size() < PHASE_ITEMS)
				push_random();
			wait_idle();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/cfrx_pkg.sv
rtl/core/cfrx_assembler.sv
rtl/core/checksummed_command_frame_receiver_top.sv
tb/tb.sv
